// ===== rtl/deblock_edge_line_filter_macros.svh =====
// Assertion macros for the checker file delf_checker.sv.
`ifndef DEBLOCK_EDGE_LINE_FILTER_MACROS_SVH
`define DEBLOCK_EDGE_LINE_FILTER_MACROS_SVH

// Check a property while out of reset.
`define DELF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define DELF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/delf_pkg.sv =====
`timescale 1ns / 1ps

package delf_pkg;

  localparam int PIX_W     = 8;
  localparam int NUM_PIX   = 8;
  localparam int STEP_W    = 8;
  localparam logic [STEP_W-1:0] STEP_RESET = 8'd8;

  typedef logic [NUM_PIX-1:0][PIX_W-1:0] delf_line_t;

  typedef struct packed {
    logic             changed;
    logic [PIX_W-1:0] new_pix5;
    logic [PIX_W-1:0] new_pix4;
  } delf_res_t;

  // (2*(p0-p3) - 5*(p1-p2) + 4) >> 3, floor shift
  function automatic logic signed [8:0] activity(
    input logic [PIX_W-1:0] p0,
    input logic [PIX_W-1:0] p1,
    input logic [PIX_W-1:0] p2,
    input logic [PIX_W-1:0] p3
  );
    logic signed [11:0] outer;
    logic signed [11:0] inner;
    logic signed [11:0] sum;
    outer = $signed({4'b0, p0}) - $signed({4'b0, p3});
    inner = $signed({4'b0, p1}) - $signed({4'b0, p2});
    sum   = (outer <<< 1) - ((inner <<< 2) + inner) + 12'sd4;
    return sum[11:3];
  endfunction

  function automatic logic [7:0] abs9(input logic signed [8:0] x);
    logic signed [8:0] mag;
    mag = x[8] ? -x : x;
    return mag[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] clamp8(input logic signed [9:0] x);
    if (x[9]) begin
      return '0;
    end else if (x[8]) begin
      return '1;
    end
    return x[7:0];
  endfunction

endpackage

// ===== rtl/deblock_edge_line_filter.sv =====
// Input register, then result register; the filter arithmetic sits between the two.
// Throughput: one line per cycle while the result side is not stalled.
// Back-pressure on the result side stalls the input register only when both are full.
// Reset (rst, synchronous, active high) empties both registers and loads step_size with 8.
`timescale 1ns / 1ps

module deblock_edge_line_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [delf_pkg::STEP_W-1:0] cfg_wdata,   // step_size
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata, // pix1, pix2, ..., pix8
  input  logic                        s_axis_tlast, // last_line
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata, // new_pix4, new_pix5
  output logic                        m_axis_tuser, // changed
  output logic                        m_axis_tlast  // last
);
  import delf_pkg::*;

  logic [STEP_W-1:0] step_size;
  logic              in_valid;
  delf_line_t        in_line;
  logic              in_last;
  logic              out_valid;
  delf_res_t         out_res;
  logic              out_last;
  delf_res_t         res_next;
  logic              out_adv;
  logic              in_adv;

  assign out_adv       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_adv;
  assign in_adv        = s_axis_tvalid && s_axis_tready;

  delf_core u_core (
    .line      (in_line),
    .step_size (step_size),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_RESET;
    end else if (cfg_wen) begin
      step_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      in_line <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (out_adv && in_valid) begin
      out_res  <= res_next;
      out_last <= in_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.new_pix5, out_res.new_pix4};
  assign m_axis_tuser  = out_res.changed;
  assign m_axis_tlast  = out_last;

endmodule

// ===== rtl/delf_core.sv =====
`timescale 1ns / 1ps

module delf_core (
  input  delf_pkg::delf_line_t         line,
  input  logic [delf_pkg::STEP_W-1:0]  step_size,
  output delf_pkg::delf_res_t          res
);
  import delf_pkg::*;

  logic signed [8:0]  a30;
  logic [7:0]         abs30;
  logic [7:0]         abs31;
  logic [7:0]         abs32;
  logic [7:0]         m;
  logic signed [8:0]  d;
  logic signed [8:0]  d_adj;
  logic signed [7:0]  c;
  logic [8:0]         diff_pos;
  logic [10:0]        prod_pos;
  logic [7:0]         a_pos;
  logic signed [11:0] diff_neg;
  logic signed [11:0] prod_neg;
  logic signed [8:0]  a_neg;
  logic               gate;
  logic               take_pos;
  logic               take_neg;
  logic signed [8:0]  a;
  logic signed [9:0]  n4;
  logic signed [9:0]  n5;

  always_comb begin
    a30   = activity(line[2], line[3], line[4], line[5]);
    abs30 = abs9(a30);
    abs31 = abs9(activity(line[0], line[1], line[2], line[3]));
    abs32 = abs9(activity(line[4], line[5], line[6], line[7]));
    m     = (abs31 < abs32) ? abs31 : abs32;

    d     = $signed({1'b0, line[3]}) - $signed({1'b0, line[4]});
    d_adj = d + $signed({8'b0, d[8]});
    c     = d_adj[8:1];

    diff_pos = {1'b0, abs30} - {1'b0, m};
    prod_pos = {diff_pos, 2'b0} + {2'b0, diff_pos};
    a_pos    = prod_pos[10:3];

    diff_neg = $signed({4'b0, m}) - $signed({4'b0, abs30});
    prod_neg = (diff_neg <<< 2) + diff_neg + 12'sd7;
    a_neg    = prod_neg[11:3];

    gate     = (abs30 < step_size) && (m < abs30);
    take_pos = gate && (c > 8'sd0) && a30[8];
    take_neg = gate && (c < 8'sd0) && !a30[8];

    a = '0;
    if (take_pos) begin
      a = (a_pos > c[7:0]) ? 9'(c) : $signed({1'b0, a_pos});
    end else if (take_neg) begin
      a = (a_neg < 9'(c)) ? 9'(c) : a_neg;
    end

    n4 = $signed({2'b0, line[3]}) - 10'(a);
    n5 = $signed({2'b0, line[4]}) + 10'(a);

    res.new_pix4 = clamp8(n4);
    res.new_pix5 = clamp8(n5);
    res.changed  = take_pos || take_neg;
  end

endmodule

// ===== rtl/delf_checker.sv =====
`timescale 1ns / 1ps
`include "deblock_edge_line_filter_macros.svh"

module delf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  `DELF_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result valid after reset")
  `DELF_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
  `DELF_ASSERT(a_latency, s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid, "no result two cycles after input transaction")
  `DELF_ASSERT(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty result register")

endmodule

bind deblock_edge_line_filter delf_checker u_delf_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  import delf_pkg::*;

  typedef struct packed {
    logic [7:0] p4;
    logic [7:0] p5;
    logic       chg;
    logic       eos;
  } line_out_t;

  typedef struct {
    logic [7:0] step;
    delf_line_t pix;
    logic       eos;
    bit         typed;
    line_out_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  line_out_t   lines_due[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  step_now = STEP_RESET;
  logic [7:0]  phase_steps[6];
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          mismatches = 0;

  deblock_edge_line_filter u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int grad_activity(input int p0, input int p1, input int p2, input int p3);
    return (2 * (p0 - p3) - 5 * (p1 - p2) + 4) >>> 3;
  endfunction

  function automatic int mag(input int x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic [7:0] sat8(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return x[7:0];
  endfunction

  function automatic line_out_t filter_line(input delf_line_t ln, input logic eos,
                                            input logic [7:0] step);
    int        v[8];
    int        a30;
    int        m30;
    int        mn;
    int        half;
    int        corr;
    logic      hit;
    line_out_t r;
    for (int i = 0; i < 8; i++) v[i] = int'(ln[i]);
    hit  = 1'b0;
    corr = 0;
    a30  = grad_activity(v[2], v[3], v[4], v[5]);
    m30  = mag(a30);
    if (m30 < int'(step)) begin
      mn = mag(grad_activity(v[0], v[1], v[2], v[3]));
      if (mag(grad_activity(v[4], v[5], v[6], v[7])) < mn)
        mn = mag(grad_activity(v[4], v[5], v[6], v[7]));
      if (mn < m30) begin
        half = (v[3] - v[4]) / 2;
        if (half > 0 && a30 < 0) begin
          corr = (5 * (m30 - mn)) >>> 3;
          if (corr > half) corr = half;
          hit = 1'b1;
        end else if (half < 0 && a30 >= 0) begin
          corr = (5 * (mn - m30) + 7) >>> 3;
          if (corr < half) corr = half;
          hit = 1'b1;
        end
      end
    end
    r.p4  = sat8(hit ? v[3] - corr : v[3]);
    r.p5  = sat8(hit ? v[4] + corr : v[4]);
    r.chg = hit;
    r.eos = eos;
    return r;
  endfunction

  function automatic delf_line_t smooth_line();
    int         lo_base;
    int         hi_base;
    int         spread;
    int         base;
    delf_line_t ln;
    if ($urandom_range(0, 9) < 2)
      lo_base = $urandom_range(0, 1) ? int'($urandom_range(0, 10)) : int'($urandom_range(245, 255));
    else
      lo_base = $urandom_range(0, 255);
    hi_base = lo_base + int'($urandom_range(0, 80)) - 40;
    spread  = $urandom_range(0, 6);
    for (int i = 0; i < 8; i++) begin
      base  = (i < 4) ? lo_base : hi_base;
      ln[i] = sat8(base + int'($urandom_range(0, 2 * spread)) - spread);
    end
    return ln;
  endfunction

  task automatic add_row(input logic [7:0] step, input logic [63:0] pix, input logic eos,
                         input bit typed = 1'b0, input line_out_t want = '0);
    dir_row_t row;
    row.step  = step;
    row.pix   = pix;
    row.eos   = eos;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_line(input delf_line_t ln, input logic eos, input bit typed = 1'b0,
                           input line_out_t want = '0);
    @(negedge clk);
    while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ln;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    lines_due.push_back(typed ? want : filter_line(ln, eos, step_now));
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(input logic [7:0] value);
    drain();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    step_now = value;
  endtask

  always @(negedge clk) begin
    m_axis_tready <= int'($urandom_range(0, 99)) >= rx_idle_pct;
  end

  always @(posedge clk) begin
    line_out_t want;
    line_out_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser, m_axis_tlast};
      if (lines_due.size() == 0) begin
        $display("%0t: unexpected transaction p4=%0d p5=%0d chg=%b eos=%b",
                 $time, got.p4, got.p5, got.chg, got.eos);
        mismatches++;
      end else begin
        want = lines_due.pop_front();
        if (got !== want) begin
          $display("%0t: expected p4=%0d p5=%0d chg=%b eos=%b, got p4=%0d p5=%0d chg=%b eos=%b",
                   $time, want.p4, want.p5, want.chg, want.eos,
                   got.p4, got.p5, got.chg, got.eos);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    delf_line_t ln;
    add_row(8'd8,   64'h00000000_00000000, 1'b0, 1'b1, '{8'd0, 8'd0, 1'b0, 1'b0});
    add_row(8'd8,   64'hFFFFFFFF_FFFFFFFF, 1'b1, 1'b1, '{8'd255, 8'd255, 1'b0, 1'b1});
    add_row(8'd8,   64'h64646464_68686868, 1'b0);
    add_row(8'd8,   64'h64646464_78787878, 1'b0);
    add_row(8'd8,   64'h76767676_64646464, 1'b1);
    add_row(8'd8,   64'h64646464_67505065, 1'b0);
    add_row(8'd8,   64'hFF00FF00_FF00FF00, 1'b0);
    add_row(8'd8,   64'h00FF00FF_00FF00FF, 1'b1);
    add_row(8'd8,   64'hFFFFFFFF_00000000, 1'b0);
    add_row(8'd8,   64'h00000000_FFFFFFFF, 1'b0);
    add_row(8'd16,  64'h78787878_64646464, 1'b0);
    add_row(8'd16,  64'h64646464_78787878, 1'b1);
    add_row(8'd255, 64'hFFFFFFFF_00000000, 1'b0);
    add_row(8'd255, 64'h00000000_FFFFFFFF, 1'b0);
    add_row(8'd255, 64'hFF00FF00_FF00FF00, 1'b1);
    add_row(8'd0,   64'h64646464_78787878, 1'b0, 1'b1, '{8'd120, 8'd100, 1'b0, 1'b0});
    add_row(8'd0,   64'h64646464_68686868, 1'b1, 1'b1, '{8'd104, 8'd100, 1'b0, 1'b1});
    add_row(8'd1,   64'h64646464_68686868, 1'b0);
    add_row(8'd1,   64'h00000000_00000000, 1'b0);
    add_row(8'd2,   64'h64646464_68686868, 1'b1);

    phase_steps = '{8'd8, 8'd255, 8'd0, 8'($urandom_range(2, 254)), 8'd1,
                    8'($urandom_range(9, 64))};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 28;
    rx_idle_pct = 76;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].step != step_now) write_step(dir_rows[i].step);
      send_line(dir_rows[i].pix, dir_rows[i].eos, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 76 : 0;
      rx_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 28 : 0;
      write_step(phase_steps[ph]);
      repeat (300) begin
        if ($urandom_range(0, 99) < 70)
          ln = smooth_line();
        else
          ln = {$urandom, $urandom};
        send_line(ln, $urandom_range(0, 7) == 0);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
